>>> sv/uvs_pkg.sv
// Shared types, constants and the CORDIC arctangent table of the UV sphere generator.
`default_nettype none

package uvs_pkg;

	// Mesh division limits and CORDIC depth.
	localparam int MAX_DIVISIONS = 255;
	localparam int CORDIC_STEPS  = 16;
	localparam int CR_LIM        = (CORDIC_STEPS < 32) ? CORDIC_STEPS : 32;

	// CORDIC iterations handled by each pipeline stage, and the resulting stage count.
	localparam int CR_PER    = 2;
	localparam int CR_STAGES = (CR_LIM + CR_PER - 1) / CR_PER;

	// Width of the CORDIC x, y and z datapath (Q30 with headroom and sign).
	localparam int ANG_W = 33;

	// Pipelined restoring dividers: angle residual quotient bits and texture quotient bits.
	localparam int QB_ANG     = 30;
	localparam int QB_TEX     = 17;
	localparam int DV_STAGES  = 6;
	localparam int DV_ANG_PER = (QB_ANG + DV_STAGES - 1) / DV_STAGES;
	localparam int DV_TEX_PER = (QB_TEX + DV_STAGES - 1) / DV_STAGES;

	// Fixed-point constants.
	localparam logic [30:0] HALF_PI_Q30     = 31'h6487ED51;
	localparam logic [31:0] CORDIC_GAIN_Q30 = 32'h26DD3B6A;
	localparam logic [63:0] QUARTER_PI_Q62  = 64'h3243F6A8885A308D;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		REG_STACKS = 2'd0,
		REG_SLICES = 2'd1,
		REG_RADIUS = 2'd2
	} reg_idx_t;

	// Request control that travels with every pipeline slot.
	typedef struct packed {
		logic       is_tri;
		logic       second;
		logic [7:0] ring;
		logic [7:0] seg;
	} ctl_t;

	typedef logic signed [ANG_W-1:0] atan_tab_t [CR_LIM];

	// Rounded arctangent of 2^-i in Q30, from the alternating series in Q62.
	function automatic logic signed [ANG_W-1:0] atan_q30(input int i);
		logic [63:0] acc;
		longint      sum;
		longint      term;
		int          k;
		sum = 0;
		if (i == 0) begin
			acc = QUARTER_PI_Q62;
		end else begin
			for (k = 0; i * (2 * k + 1) <= 62; k++) begin
				term = longint'((64'd1 << (62 - i * (2 * k + 1))) / 64'(2 * k + 1));
				sum  = (k % 2 == 1) ? sum - term : sum + term;
			end
			acc = 64'(sum);
		end
		return ANG_W'((acc + (64'd1 << 31)) >> 32);
	endfunction

	function automatic atan_tab_t build_atan_tab();
		atan_tab_t t;
		int        i;
		for (i = 0; i < CR_LIM; i++) begin
			t[i] = atan_q30(i);
		end
		return t;
	endfunction

	localparam atan_tab_t ATAN_TAB = build_atan_tab();

endpackage

`default_nettype wire

>>> sv/uv_sphere_vertex_generator.sv
// Top level of the UV sphere vertex and triangle generator.
//
//  channel   | handshake                      | payload
//  ----------+--------------------------------+-----------------------------------------
//  request   | start in, busy out             | operation, ring, segment
//  result    | done out (one-cycle strobe)    | pos_x/y/z, norm_x/y/z, tex_u/v,
//            |                                | corner_a/b/c, last
//  config    | cfg_valid in, cfg_ready out    | cfg_index, cfg_data
//
// A request is transferred at a rising edge with start high and busy low. A vertex request
// gives one result; a cell request gives its two triangles and holds busy high for the one
// cycle in which its second triangle enters the pipe. Vertex requests may therefore follow
// each other every cycle; a cell request holds the port off while its second triangle enters.
// The throughput is set by the single result port; the pipe holds the six-stage residual
// divider and the eight-stage CORDIC among its stages. Reset clears the pipeline valid bits,
// busy and the configuration registers (16 stacks, 16 slices, radius 1.0). The receiver cannot
// stall, so the pipeline never stops: each slot moves on one stage every cycle.
`default_nettype none

module uv_sphere_vertex_generator (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               operation,
	input  logic [7:0]         ring,
	input  logic [7:0]         segment,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	output logic               done,
	output logic signed [16:0] pos_x,
	output logic signed [16:0] pos_y,
	output logic signed [16:0] pos_z,
	output logic signed [15:0] norm_x,
	output logic signed [15:0] norm_y,
	output logic signed [15:0] norm_z,
	output logic [16:0]        tex_u,
	output logic [16:0]        tex_v,
	output logic [15:0]        corner_a,
	output logic [15:0]        corner_b,
	output logic [15:0]        corner_c,
	output logic               last
);
	import uvs_pkg::*;

	// Number of registered slots ahead of the output registers.
	localparam int PIPE = 3 + DV_STAGES + 1 + CR_STAGES + 3;

	// Divider slot: quadrant, residual dividend, partial remainder and quotient per division.
	typedef struct packed {
		ctl_t               ctl;
		logic [1:0]         ph_q;
		logic               ph_neg;
		logic [QB_ANG-1:0]  ph_n;
		logic [7:0]         ph_r;
		logic [QB_ANG-1:0]  ph_quo;
		logic [1:0]         th_q;
		logic               th_neg;
		logic [QB_ANG-1:0]  th_n;
		logic [7:0]         th_r;
		logic [QB_ANG-1:0]  th_quo;
		logic [QB_TEX-1:0]  tu_n;
		logic [7:0]         tu_r;
		logic [QB_TEX-1:0]  tu_quo;
		logic [QB_TEX-1:0]  tv_n;
		logic [7:0]         tv_r;
		logic [QB_TEX-1:0]  tv_quo;
	} dv_t;

	// CORDIC slot: rotation state for both angles; texture results ride along.
	typedef struct packed {
		ctl_t              ctl;
		logic [1:0]        ph_q;
		logic [ANG_W-1:0]  ph_x;
		logic [ANG_W-1:0]  ph_y;
		logic [ANG_W-1:0]  ph_z;
		logic [1:0]        th_q;
		logic [ANG_W-1:0]  th_x;
		logic [ANG_W-1:0]  th_y;
		logic [ANG_W-1:0]  th_z;
		logic [QB_TEX-1:0] tex_u;
		logic [QB_TEX-1:0] tex_v;
	} cr_t;

	typedef struct packed {
		ctl_t        ctl;
		logic [1:0]  ph_q;
		logic [11:0] ph_rem;
		logic [1:0]  th_q;
		logic [11:0] th_rem;
	} qr_t;

	typedef struct packed {
		ctl_t              ctl;
		logic [ANG_W-1:0]  cp;
		logic [ANG_W-1:0]  sp;
		logic [ANG_W-1:0]  ct;
		logic [ANG_W-1:0]  st;
		logic [QB_TEX-1:0] tex_u;
		logic [QB_TEX-1:0] tex_v;
	} trig_t;

	typedef struct packed {
		ctl_t              ctl;
		logic [ANG_W-1:0]  n0;
		logic [ANG_W-1:0]  n1;
		logic [ANG_W-1:0]  n2;
		logic [QB_TEX-1:0] tex_u;
		logic [QB_TEX-1:0] tex_v;
	} nrm_t;

	typedef struct packed {
		ctl_t              ctl;
		logic [49:0]       p0;
		logic [49:0]       p1;
		logic [49:0]       p2;
		logic [15:0]       m0;
		logic [15:0]       m1;
		logic [15:0]       m2;
		logic [QB_TEX-1:0] tex_u;
		logic [QB_TEX-1:0] tex_v;
	} prod_t;

	// Effective division count: raised to the minimum and capped at the maximum.
	function automatic logic [7:0] eff_count(input logic [7:0] v, input logic [7:0] lo);
		logic [7:0] r;
		r = (v < lo) ? lo : v;
		if (int'(r) > MAX_DIVISIONS) begin
			r = 8'(MAX_DIVISIONS);
		end
		return r;
	endfunction

	// Nearest quarter turn of n/d with halves rounded up (at most five here).
	function automatic logic [2:0] quad_of(input logic [11:0] n, input logic [7:0] d);
		logic [2:0] q;
		int         k;
		q = 3'd0;
		for (k = 1; k <= 5; k++) begin
			if ({1'b0, n, 1'b0} >= 14'(2 * k - 1) * {6'b0, d}) begin
				q = q + 3'd1;
			end
		end
		return q;
	endfunction

	// One restoring division step: returns the quotient bit and the new remainder.
	function automatic logic [8:0] div_step(input logic [7:0] r, input logic b,
			input logic [7:0] d);
		logic [8:0] t;
		t = {r, b};
		if (t >= {1'b0, d}) begin
			return {1'b1, 8'(t - {1'b0, d})};
		end
		return {1'b0, t[7:0]};
	endfunction

	// Round half up by 2^30 on a signed value.
	function automatic logic [ANG_W-1:0] rnd30(input logic signed [65:0] v);
		logic signed [65:0] t;
		t = (v + 66'sd536870912) >>> 30;
		return t[ANG_W-1:0];
	endfunction

	// ---------------------------------------------------------------------------------------
	// Configuration registers. Writes are always taken; an unknown index changes nothing.
	// ---------------------------------------------------------------------------------------
	logic [7:0]  stack_q;
	logic [7:0]  slice_q;
	logic [15:0] radius_q;
	logic [7:0]  stacks;
	logic [7:0]  slices;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stack_q  <= 8'd16;
			slice_q  <= 8'd16;
			radius_q <= 16'd256;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_STACKS: stack_q  <= cfg_data[7:0];
				REG_SLICES: slice_q  <= cfg_data[7:0];
				REG_RADIUS: radius_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// The user must change registers only with the pipeline empty (not enforced): every stage reads them live.
	assign stacks = eff_count(stack_q, 8'd2);
	assign slices = eff_count(slice_q, 8'd3);

	// ---------------------------------------------------------------------------------------
	// Request entry. A cell request takes two slots: its first triangle enters with the
	// transfer and its second one in the next cycle, while busy holds the request port off.
	// ---------------------------------------------------------------------------------------
	logic       accept;
	logic       inject;
	logic       busy_q;
	logic [7:0] held_ring_q;
	logic [7:0] held_seg_q;
	logic [7:0] src_ring;
	logic [7:0] src_seg;
	logic       src_cell;
	logic [7:0] lim_ring;
	logic [7:0] lim_seg;
	ctl_t       entry;

	assign busy   = busy_q;
	assign accept = start && !busy_q;
	assign inject = accept || busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else begin
			busy_q <= accept && operation;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			held_ring_q <= ring;
			held_seg_q  <= segment;
		end
	end

	always_comb begin
		src_ring = busy_q ? held_ring_q : ring;
		src_seg  = busy_q ? held_seg_q : segment;
		src_cell = busy_q || operation;
		// Vertices run up to the count itself; cells stop one short of it.
		lim_ring = src_cell ? stacks - 8'd1 : stacks;
		lim_seg  = src_cell ? slices - 8'd1 : slices;
		entry.is_tri = src_cell;
		entry.second = busy_q;
		entry.ring   = (src_ring > lim_ring) ? lim_ring : src_ring;
		entry.seg    = (src_seg > lim_seg) ? lim_seg : src_seg;
	end

	// Valid bits travel alongside the payload slots.
	logic [PIPE:1] vld_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
			done  <= 1'b0;
		end else begin
			vld_s <= {vld_s[PIPE-1:1], inject};
			done  <= vld_s[PIPE];
		end
	end

	ctl_t req_s1;

	always_ff @(posedge clk) begin
		req_s1 <= entry;
	end

	// ---------------------------------------------------------------------------------------
	// Stage 2: split both angles into a nearest quarter turn and a signed remainder.
	// phi is (2*ring/stacks) quarter turns, theta is ((slices + 4*segment)/slices).
	// ---------------------------------------------------------------------------------------
	qr_t         qr_s2;
	logic [11:0] n_ph;
	logic [11:0] n_th;
	logic [2:0]  q_ph;
	logic [2:0]  q_th;

	always_comb begin
		n_ph = {3'b0, req_s1.ring, 1'b0};
		n_th = 12'(slices) + {2'b0, req_s1.seg, 2'b0};
		q_ph = quad_of(n_ph, stacks);
		q_th = quad_of(n_th, slices);
	end

	always_ff @(posedge clk) begin
		qr_s2.ctl    <= req_s1;
		qr_s2.ph_q   <= q_ph[1:0];
		qr_s2.ph_rem <= n_ph - 12'(q_ph) * 12'(stacks);
		qr_s2.th_q   <= q_th[1:0];
		qr_s2.th_rem <= n_th - 12'(q_th) * 12'(slices);
	end

	// ---------------------------------------------------------------------------------------
	// Stage 3: scale the remainder magnitudes by pi/2 and set up the four dividers.
	// ---------------------------------------------------------------------------------------
	dv_t         dv_s [DV_STAGES+1];
	logic [7:0]  mag_ph;
	logic [7:0]  mag_th;
	logic [37:0] dnd_ph;
	logic [37:0] dnd_th;
	logic [23:0] dnd_tu;
	logic [23:0] dnd_tv;

	always_comb begin
		mag_ph = qr_s2.ph_rem[11] ? 8'(-qr_s2.ph_rem) : qr_s2.ph_rem[7:0];
		mag_th = qr_s2.th_rem[11] ? 8'(-qr_s2.th_rem) : qr_s2.th_rem[7:0];
		dnd_ph = 38'(mag_ph) * 38'(HALF_PI_Q30) + 38'(stacks[7:1]);
		dnd_th = 38'(mag_th) * 38'(HALF_PI_Q30) + 38'(slices[7:1]);
		dnd_tu = {qr_s2.ctl.seg, 16'b0} + 24'(slices[7:1]);
		dnd_tv = {qr_s2.ctl.ring, 16'b0} + 24'(stacks[7:1]);
	end

	always_ff @(posedge clk) begin
		dv_s[0].ctl    <= qr_s2.ctl;
		dv_s[0].ph_q   <= qr_s2.ph_q;
		dv_s[0].ph_neg <= qr_s2.ph_rem[11];
		dv_s[0].ph_n   <= dnd_ph[QB_ANG-1:0];
		dv_s[0].ph_r   <= dnd_ph[37:QB_ANG];
		dv_s[0].ph_quo <= '0;
		dv_s[0].th_q   <= qr_s2.th_q;
		dv_s[0].th_neg <= qr_s2.th_rem[11];
		dv_s[0].th_n   <= dnd_th[QB_ANG-1:0];
		dv_s[0].th_r   <= dnd_th[37:QB_ANG];
		dv_s[0].th_quo <= '0;
		dv_s[0].tu_n   <= dnd_tu[QB_TEX-1:0];
		dv_s[0].tu_r   <= {1'b0, dnd_tu[23:QB_TEX]};
		dv_s[0].tu_quo <= '0;
		dv_s[0].tv_n   <= dnd_tv[QB_TEX-1:0];
		dv_s[0].tv_r   <= {1'b0, dnd_tv[23:QB_TEX]};
		dv_s[0].tv_quo <= '0;
	end

	// Divider stages: a few restoring steps each, quotient bits from the top down.
	for (genvar g = 0; g < DV_STAGES; g++) begin : g_div
		dv_t nx;

		always_comb begin
			logic [8:0] sr;
			int         j;
			nx = dv_s[g];
			for (int k = 0; k < DV_ANG_PER; k++) begin
				j = QB_ANG - 1 - (g * DV_ANG_PER + k);
				if (j >= 0) begin
					sr           = div_step(nx.ph_r, nx.ph_n[j], stacks);
					nx.ph_r      = sr[7:0];
					nx.ph_quo[j] = sr[8];
					sr           = div_step(nx.th_r, nx.th_n[j], slices);
					nx.th_r      = sr[7:0];
					nx.th_quo[j] = sr[8];
				end
			end
			for (int k = 0; k < DV_TEX_PER; k++) begin
				j = QB_TEX - 1 - (g * DV_TEX_PER + k);
				if (j >= 0) begin
					sr           = div_step(nx.tu_r, nx.tu_n[j], slices);
					nx.tu_r      = sr[7:0];
					nx.tu_quo[j] = sr[8];
					sr           = div_step(nx.tv_r, nx.tv_n[j], stacks);
					nx.tv_r      = sr[7:0];
					nx.tv_quo[j] = sr[8];
				end
			end
		end

		always_ff @(posedge clk) begin
			dv_s[g+1] <= nx;
		end
	end

	// ---------------------------------------------------------------------------------------
	// CORDIC entry: the residual angle takes the sign of the remainder; x starts at the gain.
	// ---------------------------------------------------------------------------------------
	cr_t cr_s [CR_STAGES+1];

	always_ff @(posedge clk) begin
		cr_s[0].ctl   <= dv_s[DV_STAGES].ctl;
		cr_s[0].ph_q  <= dv_s[DV_STAGES].ph_q;
		cr_s[0].ph_x  <= ANG_W'(CORDIC_GAIN_Q30);
		cr_s[0].ph_y  <= '0;
		cr_s[0].ph_z  <= dv_s[DV_STAGES].ph_neg ? -ANG_W'(dv_s[DV_STAGES].ph_quo)
				: ANG_W'(dv_s[DV_STAGES].ph_quo);
		cr_s[0].th_q  <= dv_s[DV_STAGES].th_q;
		cr_s[0].th_x  <= ANG_W'(CORDIC_GAIN_Q30);
		cr_s[0].th_y  <= '0;
		cr_s[0].th_z  <= dv_s[DV_STAGES].th_neg ? -ANG_W'(dv_s[DV_STAGES].th_quo)
				: ANG_W'(dv_s[DV_STAGES].th_quo);
		cr_s[0].tex_u <= dv_s[DV_STAGES].tu_quo;
		cr_s[0].tex_v <= dv_s[DV_STAGES].tv_quo;
	end

	// CORDIC rotation stages, both angles side by side, floor shifts on x and y.
	for (genvar g = 0; g < CR_STAGES; g++) begin : g_cordic
		cr_t nx;

		always_comb begin
			logic signed [ANG_W-1:0] dx;
			logic signed [ANG_W-1:0] dy;
			int                      i;
			nx = cr_s[g];
			for (int k = 0; k < CR_PER; k++) begin
				i = g * CR_PER + k;
				if (i < CR_LIM) begin
					dx = $signed(nx.ph_y) >>> i;
					dy = $signed(nx.ph_x) >>> i;
					if (!nx.ph_z[ANG_W-1]) begin
						nx.ph_x = nx.ph_x - dx;
						nx.ph_y = nx.ph_y + dy;
						nx.ph_z = nx.ph_z - ATAN_TAB[i];
					end else begin
						nx.ph_x = nx.ph_x + dx;
						nx.ph_y = nx.ph_y - dy;
						nx.ph_z = nx.ph_z + ATAN_TAB[i];
					end
					dx = $signed(nx.th_y) >>> i;
					dy = $signed(nx.th_x) >>> i;
					if (!nx.th_z[ANG_W-1]) begin
						nx.th_x = nx.th_x - dx;
						nx.th_y = nx.th_y + dy;
						nx.th_z = nx.th_z - ATAN_TAB[i];
					end else begin
						nx.th_x = nx.th_x + dx;
						nx.th_y = nx.th_y - dy;
						nx.th_z = nx.th_z + ATAN_TAB[i];
					end
				end
			end
		end

		always_ff @(posedge clk) begin
			cr_s[g+1] <= nx;
		end
	end

	// ---------------------------------------------------------------------------------------
	// Quadrant restore: rotate the residual result by the whole quarter turns.
	// ---------------------------------------------------------------------------------------
	trig_t trig_s19;
	cr_t   cf;

	assign cf = cr_s[CR_STAGES];

	always_ff @(posedge clk) begin
		trig_s19.ctl   <= cf.ctl;
		trig_s19.tex_u <= cf.tex_u;
		trig_s19.tex_v <= cf.tex_v;
		unique case (cf.ph_q)
			2'd0: begin trig_s19.cp <= cf.ph_x;  trig_s19.sp <= cf.ph_y;  end
			2'd1: begin trig_s19.cp <= -cf.ph_y; trig_s19.sp <= cf.ph_x;  end
			2'd2: begin trig_s19.cp <= -cf.ph_x; trig_s19.sp <= -cf.ph_y; end
			default: begin trig_s19.cp <= cf.ph_y; trig_s19.sp <= -cf.ph_x; end
		endcase
		unique case (cf.th_q)
			2'd0: begin trig_s19.ct <= cf.th_x;  trig_s19.st <= cf.th_y;  end
			2'd1: begin trig_s19.ct <= -cf.th_y; trig_s19.st <= cf.th_x;  end
			2'd2: begin trig_s19.ct <= -cf.th_x; trig_s19.st <= -cf.th_y; end
			default: begin trig_s19.ct <= cf.th_y; trig_s19.st <= -cf.th_x; end
		endcase
	end

	// ---------------------------------------------------------------------------------------
	// Unit normal in Q30: (sin phi cos theta, cos phi, sin phi sin theta).
	// ---------------------------------------------------------------------------------------
	nrm_t nrm_s20;

	always_ff @(posedge clk) begin
		nrm_s20.ctl   <= trig_s19.ctl;
		nrm_s20.tex_u <= trig_s19.tex_u;
		nrm_s20.tex_v <= trig_s19.tex_v;
		nrm_s20.n0    <= rnd30($signed(trig_s19.sp) * $signed(trig_s19.ct));
		nrm_s20.n1    <= trig_s19.cp;
		nrm_s20.n2    <= rnd30($signed(trig_s19.sp) * $signed(trig_s19.st));
	end

	// ---------------------------------------------------------------------------------------
	// Position products with the radius, and the normals rounded and clamped to Q1.14.
	// ---------------------------------------------------------------------------------------
	prod_t prod_s21;

	function automatic logic [15:0] norm_q14(input logic [ANG_W-1:0] n);
		logic signed [ANG_W:0] t;
		t = ($signed({n[ANG_W-1], n}) + (ANG_W+1)'(32768)) >>> 16;
		if (t > (ANG_W+1)'(16384)) begin
			return 16'sd16384;
		end
		if (t < -(ANG_W+1)'(16384)) begin
			return -16'sd16384;
		end
		return t[15:0];
	endfunction

	always_ff @(posedge clk) begin
		prod_s21.ctl   <= nrm_s20.ctl;
		prod_s21.tex_u <= nrm_s20.tex_u;
		prod_s21.tex_v <= nrm_s20.tex_v;
		prod_s21.p0    <= $signed({1'b0, radius_q}) * $signed(nrm_s20.n0);
		prod_s21.p1    <= $signed({1'b0, radius_q}) * $signed(nrm_s20.n1);
		prod_s21.p2    <= $signed({1'b0, radius_q}) * $signed(nrm_s20.n2);
		prod_s21.m0    <= norm_q14(nrm_s20.n0);
		prod_s21.m1    <= norm_q14(nrm_s20.n1);
		prod_s21.m2    <= norm_q14(nrm_s20.n2);
	end

	// ---------------------------------------------------------------------------------------
	// Output stage: positions rounded and clamped to Q8.8, or a triangle's three indices.
	// Vertex k of the mesh sits at ring*(slices+1) + segment.
	// ---------------------------------------------------------------------------------------
	function automatic logic [16:0] pos_q8(input logic [49:0] p);
		logic signed [49:0] t;
		t = ($signed(p) + 50'sd536870912) >>> 30;
		if (t > 50'sd65535) begin
			return 17'sd65535;
		end
		if (t < -50'sd65535) begin
			return -17'sd65535;
		end
		return t[16:0];
	endfunction

	logic [16:0] idx_a;
	logic [16:0] idx_b;

	always_comb begin
		idx_a = 17'(prod_s21.ctl.ring) * (17'(slices) + 17'd1) + 17'(prod_s21.ctl.seg);
		idx_b = idx_a + 17'(slices) + 17'd1;
	end

	always_ff @(posedge clk) begin
		if (prod_s21.ctl.is_tri) begin
			pos_x  <= '0;
			pos_y  <= '0;
			pos_z  <= '0;
			norm_x <= '0;
			norm_y <= '0;
			norm_z <= '0;
			tex_u  <= '0;
			tex_v  <= '0;
			last   <= prod_s21.ctl.second;
			// First triangle (a, a+1, b); second triangle (b, a+1, b+1).
			if (prod_s21.ctl.second) begin
				corner_a <= idx_b[15:0];
				corner_b <= 16'(idx_a + 17'd1);
				corner_c <= 16'(idx_b + 17'd1);
			end else begin
				corner_a <= idx_a[15:0];
				corner_b <= 16'(idx_a + 17'd1);
				corner_c <= idx_b[15:0];
			end
		end else begin
			pos_x    <= pos_q8(prod_s21.p0);
			pos_y    <= pos_q8(prod_s21.p1);
			pos_z    <= pos_q8(prod_s21.p2);
			norm_x   <= prod_s21.m0;
			norm_y   <= prod_s21.m1;
			norm_z   <= prod_s21.m2;
			tex_u    <= prod_s21.tex_u;
			tex_v    <= prod_s21.tex_v;
			corner_a <= '0;
			corner_b <= '0;
			corner_c <= '0;
			last     <= 1'b1;
		end
	end

endmodule

`default_nettype wire
